/* hw/rtl/gyro_oscillation_p_gain_tuner_top_defines.svh */
// Assertion macros for the gyro P-gain tuner.
// Used by the port checker; no other dependencies.
`ifndef GYRO_OSCILLATION_P_GAIN_TUNER_TOP_DEFINES_SVH
`define GYRO_OSCILLATION_P_GAIN_TUNER_TOP_DEFINES_SVH

// Clocked assertion, aborted while reset is high.
`define GOPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset.
`define GOPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

/* hw/rtl/gopt_pkg.sv */
// Shared types and constants of the gyro P-gain tuner.
// No dependencies.
package gopt_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int GYRO_W      = 16;
   localparam int GAIN_W      = 8;
   localparam int NUM_AXES    = 3;
   localparam int AXIS_W      = 2;
   localparam int LIM_W       = GAIN_W * NUM_AXES;
   localparam int SETTLE_W    = 15;
   localparam int AVGC_W      = 8;
   localparam int PHASE_W     = 16;
   localparam int SUM_W       = GYRO_W + AVGC_W;
   localparam int AVG_MAG_W   = GYRO_W + 1;
   localparam int FRAC_W      = 16;
   localparam int FRAC_SHIFT  = 6;
   localparam int IP_W        = FRAC_W - FRAC_SHIFT;
   localparam int STEP_W      = FRAC_W + 2;
   localparam int DELTA_W     = 11;
   localparam int DIFF_W      = GYRO_W + 2;
   localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = LIM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMITS     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMITS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_GAINS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_CYCLES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_CYCLES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOOST          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_ENABLE     = 3'd6;

   localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;
   localparam logic [AXIS_W-1:0] AXIS_NONE  = 2'd3;

   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [AVGC_W-1:0] AVGC_RESET = 8'd16;

   localparam int QS_YAW  = 5;    // yaw quantized to 32
   localparam int QS_RP   = 7;    // roll and pitch quantized to 128
   localparam int TH_YAW  = 20;
   localparam int TH_RP   = 10;
   localparam int INC_YAW = 256;
   localparam int INC_RP  = 64;
   localparam int DEC_YAW = 64;
   localparam int DEC_RP  = 32;

   localparam int FRAC_MAX = 32767;
   localparam int FRAC_MIN = -32768;
   localparam logic signed [GYRO_W-1:0] GYRO_MAX = 16'sh7fff;
   localparam logic signed [GYRO_W-1:0] GYRO_MIN = 16'sh8000;
   localparam logic signed [PHASE_W-1:0] PHASE_MAX = 16'sh7fff;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_ERR,
      ST_DECIDE,
      ST_STEP,
      ST_CLAMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic div_start;
      logic err_calc;
      logic decide;
      logic step;
      logic clamp;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

/* hw/rtl/gopt_if.sv */
// Valid/ready channel interfaces for the gyro P-gain tuner.
// Depends on gopt_pkg.
interface gopt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 command;
   logic [gopt_pkg::AXIS_W-1:0]          axis;
   logic signed [gopt_pkg::GYRO_W-1:0]   gyro_sample;
   logic                                 stick_active;
   logic                                 level_mode;

   modport source (output valid, command, axis, gyro_sample, stick_active, level_mode,
                   input ready);
   modport sink   (input valid, command, axis, gyro_sample, stick_active, level_mode,
                   output ready);
endinterface

interface gopt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [gopt_pkg::AXIS_W-1:0]          out_axis;
   logic [gopt_pkg::GAIN_W-1:0]          gain;
   logic                                 gain_updated;
   logic signed [gopt_pkg::GYRO_W-1:0]   average_rate;

   modport source (output valid, out_axis, gain, gain_updated, average_rate,
                   input ready);
   modport sink   (input valid, out_axis, gain, gain_updated, average_rate,
                   output ready);
endinterface

/* hw/rtl/gopt_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on gopt_pkg.
module gopt_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [gopt_pkg::SUM_W-1:0]      dividend,
   input  logic [gopt_pkg::AVGC_W-1:0]     divisor,
   output logic [gopt_pkg::SUM_W-1:0]      quotient,
   output logic                            done
);

   logic [gopt_pkg::SUM_W-1:0]     quo_ff, quo_in;
   logic [gopt_pkg::AVGC_W-1:0]    rem_ff, rem_in;
   logic [gopt_pkg::AVGC_W-1:0]    den_ff;
   logic [gopt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [gopt_pkg::AVGC_W:0]      trial;
   logic [gopt_pkg::AVGC_W:0]      trial_sub;
   logic                           trial_ge;

   always_comb begin
      trial     = {rem_ff, quo_ff[gopt_pkg::SUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      trial_ge  = trial >= {1'b0, den_ff};
      rem_in    = trial_ge ? trial_sub[gopt_pkg::AVGC_W-1:0] : trial[gopt_pkg::AVGC_W-1:0];
      quo_in    = {quo_ff[gopt_pkg::SUM_W-2:0], trial_ge};
      cnt_in    = cnt_ff - gopt_pkg::DIV_CNT_W'(1);
      done_in   = cnt_ff == gopt_pkg::DIV_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= gopt_pkg::DIV_CNT_W'(gopt_pkg::SUM_W);
         done_ff <= 1'b0;
      end else if (cnt_ff != '0) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* hw/rtl/gopt_ctrl.sv */
// Sequencer of the gyro P-gain tuner: one item at a time.
// Depends on gopt_pkg; drives the datapath by command struct.
module gopt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  gopt_pkg::dp_status_type  status,
   output gopt_pkg::ctrl_cmd_type   cmd
);

   gopt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gopt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         gopt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = gopt_pkg::ST_LOAD;
            end
         end
         gopt_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = gopt_pkg::ST_DIV;
            end else begin
               state_in = gopt_pkg::ST_OUT;
            end
         end
         gopt_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = gopt_pkg::ST_ERR;
            end
         end
         gopt_pkg::ST_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = gopt_pkg::ST_DECIDE;
         end
         gopt_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = gopt_pkg::ST_STEP;
         end
         gopt_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            state_in = gopt_pkg::ST_CLAMP;
         end
         gopt_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = gopt_pkg::ST_OUT;
         end
         gopt_pkg::ST_OUT: begin
            // wait until the result register can take the transfer
            if (status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = gopt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gopt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/gopt_dp.sv */
// Datapath of the gyro P-gain tuner: registers, per-axis state, divider, result register.
// Depends on gopt_pkg, gopt_if and gopt_div.
module gopt_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gopt_pkg::ctrl_cmd_type                cmd,
   output gopt_pkg::dp_status_type               status,
   input  logic                                  req_command,
   input  logic [gopt_pkg::AXIS_W-1:0]           req_axis,
   input  logic signed [gopt_pkg::GYRO_W-1:0]    req_gyro_sample,
   input  logic                                  req_stick_active,
   input  logic                                  req_level_mode,
   gopt_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [gopt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gopt_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int NA = gopt_pkg::NUM_AXES;
   localparam int GW = gopt_pkg::GAIN_W;

   // configuration
   logic [gopt_pkg::LIM_W-1:0]    low_lim_ff, high_lim_ff, init_gain_ff;
   logic [gopt_pkg::SETTLE_W-1:0] settle_ff;
   logic [gopt_pkg::AVGC_W-1:0]   avgc_ff;
   logic [gopt_pkg::AVGC_W-1:0]   boost_ff;
   logic                          yaw_en_ff;

   // captured item
   logic                                 it_cmd_ff;
   logic [gopt_pkg::AXIS_W-1:0]          it_axis_ff;
   logic signed [gopt_pkg::GYRO_W-1:0]   it_sample_ff;
   logic                                 it_stick_ff;
   logic                                 it_level_ff;

   // per-axis state
   logic signed [gopt_pkg::GYRO_W-1:0]  prev_err_ff [NA];
   logic signed [gopt_pkg::PHASE_W-1:0] phase_ff    [NA];
   logic signed [gopt_pkg::SUM_W-1:0]   sum_ff      [NA];
   logic signed [gopt_pkg::FRAC_W-1:0]  frac_ff     [NA];
   logic [GW-1:0]                       gain_ff     [NA];
   logic [GW-1:0]                       tune_hi_ff  [NA];
   logic signed [gopt_pkg::GYRO_W-1:0]  last_avg_ff [NA];

   // decision pipeline
   logic                                 sum_neg_ff;
   logic signed [gopt_pkg::GYRO_W-1:0]   err_ff;
   logic                                 upd_ff;
   logic                                 step_en_ff;
   logic signed [gopt_pkg::DELTA_W-1:0]  delta_ff;

   // result register
   logic                                 rsp_valid_ff;
   logic [gopt_pkg::AXIS_W-1:0]          rsp_axis_ff;
   logic [GW-1:0]                        rsp_gain_ff;
   logic                                 rsp_upd_ff;
   logic signed [gopt_pkg::GYRO_W-1:0]   rsp_avg_ff;

   logic                                 ax_ok, is_yaw, disturb;
   logic signed [gopt_pkg::GYRO_W-1:0]   s_ext, s_floor, quant;
   logic                                 low_nz;
   logic signed [gopt_pkg::PHASE_W-1:0]  phase_cur, phase_nx, settle_neg;
   logic signed [gopt_pkg::SUM_W-1:0]    sum_base, sum_nx;
   logic [gopt_pkg::SUM_W-1:0]           sum_abs;
   logic [gopt_pkg::AVGC_W-1:0]          target;
   logic                                 hit;
   logic [gopt_pkg::SUM_W-1:0]           quotient;
   logic                                 div_done;
   logic [gopt_pkg::AVG_MAG_W-1:0]       q_mag;
   logic signed [gopt_pkg::AVG_MAG_W-1:0] avg_full;
   logic signed [gopt_pkg::GYRO_W-1:0]   avg_c, err_c, prev_cur;
   logic [gopt_pkg::AVG_MAG_W-1:0]       ext_e, ext_p, abs_e, abs_p;
   logic signed [gopt_pkg::DIFF_W-1:0]   diff_c, th_c, nth_c;
   logic                                 tune_c, same_c, up_c, down_c, flip_c;
   logic signed [gopt_pkg::DELTA_W-1:0]  delta_up, delta_dn, delta_c;
   logic signed [gopt_pkg::STEP_W-1:0]   t_c;
   logic signed [gopt_pkg::FRAC_W-1:0]   frac_sat;
   logic signed [gopt_pkg::IP_W-1:0]     ip_c, lo_s, hi_s;
   logic [GW-1:0]                        lo_cur, hi_cur, clamp_c;
   logic [GW-1:0]                        rs_hi   [NA];
   logic [GW-1:0]                        rs_gain [NA];

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         low_lim_ff   <= '0;
         high_lim_ff  <= '0;
         init_gain_ff <= '0;
         settle_ff    <= '0;
         avgc_ff      <= gopt_pkg::AVGC_RESET;
         boost_ff     <= '0;
         yaw_en_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            gopt_pkg::CSR_LOW_LIMITS:     low_lim_ff   <= csr_wdata;
            gopt_pkg::CSR_HIGH_LIMITS:    high_lim_ff  <= csr_wdata;
            gopt_pkg::CSR_INITIAL_GAINS:  init_gain_ff <= csr_wdata;
            gopt_pkg::CSR_SETTLE_CYCLES:  settle_ff    <= csr_wdata[gopt_pkg::SETTLE_W-1:0];
            gopt_pkg::CSR_AVERAGE_CYCLES: avgc_ff      <= csr_wdata[gopt_pkg::AVGC_W-1:0];
            gopt_pkg::CSR_BOOST:          boost_ff     <= csr_wdata[gopt_pkg::AVGC_W-1:0];
            gopt_pkg::CSR_YAW_ENABLE:     yaw_en_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // ---- item capture ----
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         it_cmd_ff    <= req_command;
         it_axis_ff   <= req_axis;
         it_sample_ff <= req_gyro_sample;
         it_stick_ff  <= req_stick_active;
         it_level_ff  <= req_level_mode;
      end
   end

   // ---- restart values, all axes at once ----
   always_comb begin
      logic [GW-1:0] lo, hi, g;
      logic          kill;
      for (int a = 0; a < NA; a++) begin
         lo   = low_lim_ff[GW*a +: GW];
         hi   = high_lim_ff[GW*a +: GW];
         g    = init_gain_ff[GW*a +: GW];
         kill = (hi != '0 && lo > hi) || (a == int'(gopt_pkg::AXIS_YAW) && !yaw_en_ff);
         rs_hi[a]   = kill ? '0 : hi;
         rs_gain[a] = (g < lo) ? lo : g;
      end
   end

   // ---- sample accumulation ----
   always_comb begin
      ax_ok   = it_axis_ff != gopt_pkg::AXIS_NONE;
      is_yaw  = it_axis_ff == gopt_pkg::AXIS_YAW;
      disturb = it_stick_ff || (!is_yaw && it_level_ff);

      s_ext = gopt_pkg::GYRO_W'(signed'(it_sample_ff[gopt_pkg::SAMPLE_BITS-1:0]));
      // truncate toward zero: floor, then bump negatives that had a remainder
      if (is_yaw) begin
         s_floor = {s_ext[gopt_pkg::GYRO_W-1:gopt_pkg::QS_YAW], gopt_pkg::QS_YAW'(0)};
         low_nz  = |s_ext[gopt_pkg::QS_YAW-1:0];
      end else begin
         s_floor = {s_ext[gopt_pkg::GYRO_W-1:gopt_pkg::QS_RP], gopt_pkg::QS_RP'(0)};
         low_nz  = |s_ext[gopt_pkg::QS_RP-1:0];
      end
      if (s_ext[gopt_pkg::GYRO_W-1] && low_nz) begin
         quant = s_floor + (is_yaw ? gopt_pkg::GYRO_W'(1 << gopt_pkg::QS_YAW)
                                   : gopt_pkg::GYRO_W'(1 << gopt_pkg::QS_RP));
      end else begin
         quant = s_floor;
      end

      phase_cur  = phase_ff[it_axis_ff];
      settle_neg = -signed'(gopt_pkg::PHASE_W'(settle_ff));
      phase_nx   = (phase_cur == gopt_pkg::PHASE_MAX) ? phase_cur
                                                      : phase_cur + gopt_pkg::PHASE_W'(1);
      sum_base   = (phase_cur == '0) ? '0 : sum_ff[it_axis_ff];
      if (!phase_nx[gopt_pkg::PHASE_W-1] && phase_nx != '0) begin
         sum_nx = sum_base + gopt_pkg::SUM_W'(quant);
      end else begin
         sum_nx = sum_base;
      end
      target  = (avgc_ff == '0) ? gopt_pkg::AVGC_W'(1) : avgc_ff;
      hit     = phase_nx == gopt_pkg::PHASE_W'(target);
      sum_abs = sum_nx[gopt_pkg::SUM_W-1] ? gopt_pkg::SUM_W'(-sum_nx)
                                          : gopt_pkg::SUM_W'(sum_nx);
   end

   gopt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_abs),
      .divisor  (target),
      .quotient (quotient),
      .done     (div_done)
   );

   // ---- average, error, decision, accumulator ----
   always_comb begin
      q_mag    = quotient[gopt_pkg::AVG_MAG_W-1:0];
      avg_full = sum_neg_ff ? -signed'(q_mag) : signed'(q_mag);
      avg_c    = avg_full[gopt_pkg::GYRO_W-1:0];
      if (is_yaw) begin
         err_c = (avg_c == gopt_pkg::GYRO_MIN) ? gopt_pkg::GYRO_MAX : -avg_c;
      end else begin
         err_c = avg_c;
      end

      prev_cur = prev_err_ff[it_axis_ff];
      ext_e    = {err_ff[gopt_pkg::GYRO_W-1], err_ff};
      ext_p    = {prev_cur[gopt_pkg::GYRO_W-1], prev_cur};
      abs_e    = ext_e[gopt_pkg::AVG_MAG_W-1] ? -ext_e : ext_e;
      abs_p    = ext_p[gopt_pkg::AVG_MAG_W-1] ? -ext_p : ext_p;
      diff_c   = {1'b0, abs_e} - {1'b0, abs_p};
      th_c     = is_yaw ? gopt_pkg::DIFF_W'(gopt_pkg::TH_YAW) : gopt_pkg::DIFF_W'(gopt_pkg::TH_RP);
      nth_c    = -th_c;

      tune_c = tune_hi_ff[it_axis_ff] != '0 && err_ff != '0 && prev_cur != '0
               && err_ff != prev_cur;
      same_c = err_ff[gopt_pkg::GYRO_W-1] == prev_cur[gopt_pkg::GYRO_W-1];
      up_c   = same_c && diff_c > th_c;
      down_c = same_c && diff_c < nth_c;
      flip_c = !same_c && !is_yaw && (diff_c > th_c || diff_c < nth_c);

      delta_up = (is_yaw ? gopt_pkg::DELTA_W'(gopt_pkg::INC_YAW)
                         : gopt_pkg::DELTA_W'(gopt_pkg::INC_RP))
                 + gopt_pkg::DELTA_W'(boost_ff);
      delta_dn = is_yaw ? -(gopt_pkg::DELTA_W'(gopt_pkg::DEC_YAW) + gopt_pkg::DELTA_W'(boost_ff))
                        : -gopt_pkg::DELTA_W'(gopt_pkg::DEC_RP);
      if (up_c) begin
         delta_c = delta_up;
      end else if (down_c) begin
         delta_c = delta_dn;
      end else begin
         delta_c = -gopt_pkg::DELTA_W'(gopt_pkg::DEC_RP);
      end

      t_c = gopt_pkg::STEP_W'(frac_ff[it_axis_ff]) + gopt_pkg::STEP_W'(delta_ff);
      if (t_c > gopt_pkg::FRAC_MAX) begin
         frac_sat = gopt_pkg::FRAC_W'(gopt_pkg::FRAC_MAX);
      end else if (t_c < gopt_pkg::FRAC_MIN) begin
         frac_sat = gopt_pkg::FRAC_W'(gopt_pkg::FRAC_MIN);
      end else begin
         frac_sat = t_c[gopt_pkg::FRAC_W-1:0];
      end

      // integer part is the floor of the accumulator over 64
      ip_c   = frac_ff[it_axis_ff][gopt_pkg::FRAC_W-1:gopt_pkg::FRAC_SHIFT];
      lo_cur = low_lim_ff[GW*it_axis_ff +: GW];
      hi_cur = tune_hi_ff[it_axis_ff];
      lo_s   = gopt_pkg::IP_W'(lo_cur);
      hi_s   = gopt_pkg::IP_W'(hi_cur);
      if (ip_c < lo_s) begin
         clamp_c = lo_cur;
      end else if (ip_c > hi_s) begin
         clamp_c = hi_cur;
      end else begin
         clamp_c = ip_c[GW-1:0];
      end
   end

   // ---- per-axis state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            prev_err_ff[a] <= '0;
            phase_ff[a]    <= '0;
            sum_ff[a]      <= '0;
            frac_ff[a]     <= '0;
            gain_ff[a]     <= '0;
            tune_hi_ff[a]  <= '0;
            last_avg_ff[a] <= '0;
         end
      end else begin
         if (cmd.load) begin
            if (it_cmd_ff == gopt_pkg::CMD_RESTART) begin
               for (int a = 0; a < NA; a++) begin
                  tune_hi_ff[a]  <= rs_hi[a];
                  gain_ff[a]     <= rs_gain[a];
                  frac_ff[a]     <= gopt_pkg::FRAC_W'(rs_gain[a]) << gopt_pkg::FRAC_SHIFT;
                  prev_err_ff[a] <= '0;
                  phase_ff[a]    <= settle_neg;
               end
            end else if (ax_ok) begin
               if (disturb) begin
                  prev_err_ff[it_axis_ff] <= '0;
                  phase_ff[it_axis_ff]    <= settle_neg;
               end else begin
                  phase_ff[it_axis_ff] <= hit ? '0 : phase_nx;
                  sum_ff[it_axis_ff]   <= sum_nx;
               end
            end
         end
         if (cmd.err_calc) begin
            last_avg_ff[it_axis_ff] <= avg_c;
            sum_ff[it_axis_ff]      <= gopt_pkg::SUM_W'(avg_c);
         end
         if (cmd.decide) begin
            prev_err_ff[it_axis_ff] <= err_ff;
         end
         if (cmd.step && step_en_ff) begin
            frac_ff[it_axis_ff] <= frac_sat;
         end
         if (cmd.clamp && upd_ff) begin
            gain_ff[it_axis_ff] <= clamp_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         sum_neg_ff <= sum_nx[gopt_pkg::SUM_W-1];
      end
      if (cmd.err_calc) begin
         err_ff <= err_c;
      end
      if (cmd.decide) begin
         step_en_ff <= tune_c && (up_c || down_c || flip_c);
         delta_ff   <= delta_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff <= 1'b0;
      end else if (cmd.load) begin
         upd_ff <= 1'b0;
      end else if (cmd.decide) begin
         upd_ff <= tune_c;
      end
   end

   // ---- result register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_axis_ff <= it_axis_ff;
         rsp_upd_ff  <= ax_ok && upd_ff;
         if (ax_ok) begin
            rsp_gain_ff <= gain_ff[it_axis_ff];
            rsp_avg_ff  <= last_avg_ff[it_axis_ff];
         end else begin
            rsp_gain_ff <= '0;
            rsp_avg_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_axis     = rsp_axis_ff;
   assign rsp_chan.gain         = rsp_gain_ff;
   assign rsp_chan.gain_updated = rsp_upd_ff;
   assign rsp_chan.average_rate = rsp_avg_ff;

   always_comb begin
      status.need_div = it_cmd_ff == gopt_pkg::CMD_SAMPLE && ax_ok && !disturb && hit;
      status.div_done = div_done;
      status.rsp_free = !rsp_valid_ff || rsp_chan.ready;
   end

endmodule

/* hw/rtl/gyro_oscillation_p_gain_tuner_top.sv */
// Gyro P-gain tuner, top level: sequencer plus datapath.
// Depends on gopt_pkg, gopt_if, gopt_ctrl, gopt_dp.
// Steps: IDLE captures the item, LOAD updates the axis state, OUT loads the result
//   register; a sample that closes an average runs the 24-step restoring divider,
//   then ERR, DECIDE, STEP and CLAMP. One item at a time; OUT waits until the output
//   register is free, yet a new item is taken while the previous result still waits.
// Reset (synchronous): registers to their reset values, all axes restarted.
module gyro_oscillation_p_gain_tuner_top (
   input  logic                               clock,
   input  logic                               reset,
   gopt_req_if.sink                           req_chan,
   gopt_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [gopt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gopt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   gopt_pkg::ctrl_cmd_type  cmd;
   gopt_pkg::dp_status_type status;

   gopt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gopt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_chan.command),
      .req_axis         (req_chan.axis),
      .req_gyro_sample  (req_chan.gyro_sample),
      .req_stick_active (req_chan.stick_active),
      .req_level_mode   (req_chan.level_mode),
      .rsp_chan         (rsp_chan),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

endmodule

/* hw/rtl/gopt_chk.sv */
// Port-level checker for the gyro P-gain tuner, bound to the top level.
// Depends on gopt_pkg and the defines header.
`include "gyro_oscillation_p_gain_tuner_top_defines.svh"

module gopt_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [gopt_pkg::AXIS_W-1:0]        rsp_out_axis,
   input logic [gopt_pkg::GAIN_W-1:0]        rsp_gain,
   input logic                               rsp_gain_updated,
   input logic signed [gopt_pkg::GYRO_W-1:0] rsp_average_rate
);

   `GOPT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped while stalled")
   `GOPT_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_out_axis) && $stable(rsp_gain) && $stable(rsp_gain_updated) && $stable(rsp_average_rate), "result changed while stalled")
   `GOPT_ASSERT(a_no_axis, clock, reset, rsp_valid && rsp_out_axis == gopt_pkg::AXIS_NONE |-> rsp_gain == '0 && !rsp_gain_updated && rsp_average_rate == '0, "unused axis reported data")
   `GOPT_ASSERT(a_one_item, clock, reset, req_valid && req_ready |=> !req_ready, "second item taken while one is in flight")
   `GOPT_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind gyro_oscillation_p_gain_tuner_top gopt_chk u_gopt_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_out_axis     (rsp_chan.out_axis),
   .rsp_gain         (rsp_chan.gain),
   .rsp_gain_updated (rsp_chan.gain_updated),
   .rsp_average_rate (rsp_chan.average_rate)
);

/* dv/tb.sv */
// Testbench for gyro_oscillation_p_gain_tuner_top: directed and random traffic,
// checked against an in-bench predictor of the three-axis P-gain tuner.
// Depends on gopt_pkg, gopt_if and the tuner RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1050;
   localparam int IDLE_PCT    = 23;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      logic [gopt_pkg::AXIS_W-1:0]        axis;
      logic [gopt_pkg::GAIN_W-1:0]        gain;
      logic                               updated;
      logic signed [gopt_pkg::GYRO_W-1:0] rate;
   } gain_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                            csr_we;
   logic [gopt_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [gopt_pkg::CSR_DATA_W-1:0] csr_wdata;

   gopt_req_if req_chan();
   gopt_rsp_if rsp_chan();

   gyro_oscillation_p_gain_tuner_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor copy of the registers and of the per-axis tuning state
   logic [gopt_pkg::LIM_W-1:0] cfg_low, cfg_high, cfg_init;
   int cfg_settle, cfg_avgc, cfg_boost;
   bit cfg_yaw_en;
   int prev_err [gopt_pkg::NUM_AXES];
   int phase_cnt [gopt_pkg::NUM_AXES];
   int rate_acc [gopt_pkg::NUM_AXES];
   int gain_frac [gopt_pkg::NUM_AXES];
   int cur_gain [gopt_pkg::NUM_AXES];
   int tune_ceiling [gopt_pkg::NUM_AXES];
   int last_avg [gopt_pkg::NUM_AXES];

   gain_report_type gain_reports_due [$];
   int walk_rate [gopt_pkg::NUM_AXES];
   int items_accepted = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;
   int hold_req = 0;
   bit idle_on = 1'b1;

   function automatic int lane_of(logic [gopt_pkg::LIM_W-1:0] r, int ax);
      return int'(r[gopt_pkg::GAIN_W*ax +: gopt_pkg::GAIN_W]);
   endfunction

   function automatic int mag(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic void store_reg(logic [gopt_pkg::CSR_IDX_W-1:0] idx,
                                     logic [gopt_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         gopt_pkg::CSR_LOW_LIMITS:     cfg_low = val;
         gopt_pkg::CSR_HIGH_LIMITS:    cfg_high = val;
         gopt_pkg::CSR_INITIAL_GAINS:  cfg_init = val;
         gopt_pkg::CSR_SETTLE_CYCLES:  cfg_settle = int'(val[gopt_pkg::SETTLE_W-1:0]);
         gopt_pkg::CSR_AVERAGE_CYCLES: cfg_avgc = int'(val[gopt_pkg::AVGC_W-1:0]);
         gopt_pkg::CSR_BOOST:          cfg_boost = int'(val[gopt_pkg::GAIN_W-1:0]);
         gopt_pkg::CSR_YAW_ENABLE:     cfg_yaw_en = val[0];
         default: ;
      endcase
   endfunction

   // upper limit is latched here; a nonzero limit below the low limit disables the axis
   function automatic void restart_axes();
      int lo, hi, g;
      for (int ax = 0; ax < gopt_pkg::NUM_AXES; ax++) begin
         lo = lane_of(cfg_low, ax);
         hi = lane_of(cfg_high, ax);
         g  = lane_of(cfg_init, ax);
         if ((hi != 0 && lo > hi) || (ax == gopt_pkg::AXIS_YAW && !cfg_yaw_en))
            hi = 0;
         tune_ceiling[ax] = hi;
         if (g < lo)
            g = lo;
         cur_gain[ax]  = g;
         gain_frac[ax] = g << gopt_pkg::FRAC_SHIFT;
         prev_err[ax]  = 0;
         phase_cnt[ax] = -cfg_settle;
      end
   endfunction

   function automatic void nudge_gain(int ax, int delta);
      int t;
      t = gain_frac[ax] + delta;
      if (t > gopt_pkg::FRAC_MAX) t = gopt_pkg::FRAC_MAX;
      if (t < gopt_pkg::FRAC_MIN) t = gopt_pkg::FRAC_MIN;
      gain_frac[ax] = t;
   endfunction

   function automatic void weigh_error(int ax, int err);
      int prev, th, diff, ip, lo, hi;
      prev = prev_err[ax];
      th = (ax == gopt_pkg::AXIS_YAW) ? gopt_pkg::TH_YAW : gopt_pkg::TH_RP;
      if (tune_ceiling[ax] != 0 && err != 0 && prev != 0 && err != prev) begin
         diff = mag(err) - mag(prev);
         if ((err > 0) == (prev > 0)) begin
            if (diff > th)
               nudge_gain(ax, ((ax == gopt_pkg::AXIS_YAW) ? gopt_pkg::INC_YAW
                                                          : gopt_pkg::INC_RP) + cfg_boost);
            else if (diff < -th)
               nudge_gain(ax, (ax == gopt_pkg::AXIS_YAW) ? -(gopt_pkg::DEC_YAW + cfg_boost)
                                                         : -gopt_pkg::DEC_RP);
         end else if (mag(diff) > th && ax != gopt_pkg::AXIS_YAW) begin
            nudge_gain(ax, -gopt_pkg::DEC_RP);
         end
         ip = gain_frac[ax] >>> gopt_pkg::FRAC_SHIFT;   // floor of the fixed-point value
         lo = lane_of(cfg_low, ax);
         hi = tune_ceiling[ax];
         if (ip < lo) ip = lo;
         else if (ip > hi) ip = hi;
         cur_gain[ax] = ip & 8'hFF;
      end
      prev_err[ax] = err;
   endfunction

   function automatic gain_report_type predict_gain_report(
         logic cmd, logic [gopt_pkg::AXIS_W-1:0] axis,
         logic signed [gopt_pkg::GYRO_W-1:0] rate, logic stick, logic level);
      gain_report_type rep;
      int ax, s, q, target, avg, err, pe;
      bit updated;
      ax = int'(axis);
      updated = 1'b0;
      if (cmd == gopt_pkg::CMD_RESTART) begin
         restart_axes();
      end else if (axis != gopt_pkg::AXIS_NONE) begin
         if (stick || (axis != gopt_pkg::AXIS_YAW && level)) begin
            prev_err[ax]  = 0;
            phase_cnt[ax] = -cfg_settle;
         end else begin
            s = int'(signed'(rate[gopt_pkg::SAMPLE_BITS-1:0]));
            q = (axis == gopt_pkg::AXIS_YAW) ? (1 << gopt_pkg::QS_YAW)
                                             : (1 << gopt_pkg::QS_RP);
            target = (cfg_avgc == 0) ? 1 : cfg_avgc;
            if (phase_cnt[ax] == 0)
               rate_acc[ax] = 0;
            phase_cnt[ax]++;
            if (phase_cnt[ax] > 0)
               rate_acc[ax] += q * (s / q);
            if (phase_cnt[ax] == target) begin
               avg = rate_acc[ax] / phase_cnt[ax];
               rate_acc[ax]  = avg;
               last_avg[ax]  = avg;
               phase_cnt[ax] = 0;
               err = (axis == gopt_pkg::AXIS_YAW) ? -avg : avg;
               if (err > int'(gopt_pkg::GYRO_MAX))
                  err = int'(gopt_pkg::GYRO_MAX);
               pe = prev_err[ax];
               weigh_error(ax, err);
               updated = tune_ceiling[ax] != 0 && err != 0 && pe != 0 && err != pe;
            end
         end
      end
      rep.axis = axis;
      if (axis != gopt_pkg::AXIS_NONE) begin
         rep.gain    = gopt_pkg::GAIN_W'(cur_gain[ax]);
         rep.updated = updated;
         rep.rate    = gopt_pkg::GYRO_W'(last_avg[ax]);
      end else begin
         rep.gain    = '0;
         rep.updated = 1'b0;
         rep.rate    = '0;
      end
      return rep;
   endfunction

   task automatic send_item(input logic cmd, input logic [gopt_pkg::AXIS_W-1:0] axis,
                            input logic signed [gopt_pkg::GYRO_W-1:0] rate,
                            input logic stick, input logic level);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.axis         <= axis;
      req_chan.gyro_sample  <= rate;
      req_chan.stick_active <= stick;
      req_chan.level_mode   <= level;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      gain_reports_due.push_back(predict_gain_report(cmd, axis, rate, stick, level));
      items_accepted++;
   endtask

   // sender holds off until every pending result has come back
   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      while (gain_reports_due.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic program_regs(input logic [gopt_pkg::LIM_W-1:0] lo, hi, init,
                               input int settle, avgc, boostv, input bit yaw_on);
      logic [gopt_pkg::CSR_IDX_W-1:0]  idx [7];
      logic [gopt_pkg::CSR_DATA_W-1:0] val [7];
      idx = '{gopt_pkg::CSR_LOW_LIMITS, gopt_pkg::CSR_HIGH_LIMITS,
              gopt_pkg::CSR_INITIAL_GAINS, gopt_pkg::CSR_SETTLE_CYCLES,
              gopt_pkg::CSR_AVERAGE_CYCLES, gopt_pkg::CSR_BOOST, gopt_pkg::CSR_YAW_ENABLE};
      val = '{lo, hi, init, gopt_pkg::CSR_DATA_W'(settle), gopt_pkg::CSR_DATA_W'(avgc),
              gopt_pkg::CSR_DATA_W'(boostv), gopt_pkg::CSR_DATA_W'(yaw_on)};
      wait_drain();
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         store_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   // random walk per axis so consecutive averages grow and shrink; some jumps as noise
   function automatic logic signed [gopt_pkg::GYRO_W-1:0] next_rate(int ax);
      int span;
      case ($urandom_range(9))
         0, 1, 2: walk_rate[ax] = int'($urandom_range(65535)) - 32768;
         3:       walk_rate[ax] = $urandom_range(1) ? int'(gopt_pkg::GYRO_MIN)
                                                    : int'(gopt_pkg::GYRO_MAX);
         default: begin
            span = ($urandom_range(2) == 0) ? 40 : ($urandom_range(1) ? 400 : 4000);
            walk_rate[ax] += int'($urandom_range(2 * span)) - span;
            if (walk_rate[ax] > int'(gopt_pkg::GYRO_MAX))
               walk_rate[ax] = int'(gopt_pkg::GYRO_MAX);
            if (walk_rate[ax] < int'(gopt_pkg::GYRO_MIN))
               walk_rate[ax] = int'(gopt_pkg::GYRO_MIN);
         end
      endcase
      return gopt_pkg::GYRO_W'(walk_rate[ax]);
   endfunction

   task automatic send_random_item();
      int pick, ax;
      pick = $urandom_range(99);
      ax = $urandom_range(2);
      if (pick < 86)
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_W'(ax), next_rate(ax), 1'b0,
                   (ax == gopt_pkg::AXIS_YAW) ? 1'($urandom_range(1)) : 1'b0);
      else if (pick < 91)
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_W'(ax), next_rate(ax), 1'b1,
                   1'($urandom_range(1)));
      else if (pick < 94)
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_W'(ax), next_rate(ax), 1'b0, 1'b1);
      else if (pick < 97)
         send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_W'($urandom_range(3)),
                   gopt_pkg::GYRO_W'($urandom), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
      else
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_NONE, gopt_pkg::GYRO_W'($urandom),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
   endtask

   task automatic test_directed_cases();
      // reset values: no tuning, 16-sample averages
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, 16'sh4000, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, -16'sd1000, 1'b0, 1'b1);
      program_regs(24'h05140A, 24'h3264C8, 24'h280A32, 0, 1, 7, 1'b1);
      send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_ROLL, '0, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, gopt_pkg::GYRO_MAX, 1'b0, 1'b0);
      // same error
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, gopt_pkg::GYRO_MAX, 1'b0, 1'b0);
      // shrink
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, 16'sd16000, 1'b0, 1'b0);
      // sign flip
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, gopt_pkg::GYRO_MIN, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, -16'sd32760, 1'b0, 1'b0);
      // quantizes to zero, then to exactly -128
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, 16'sd127, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, -16'sd128, 1'b0, 1'b0);
      // level mode, then stick
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, 16'sd1280, 1'b0, 1'b1);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, 16'sd1280, 1'b1, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, 16'sd1280, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, 16'sd2560, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, -16'sd2600, 1'b0, 1'b0);
      // level mode does not block yaw; most negative average saturates the error
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, gopt_pkg::GYRO_MIN, 1'b0, 1'b1);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, -16'sd32000, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, 16'sd31, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, -16'sd32, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, -16'sd64, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, 16'sd500, 1'b1, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_NONE, 16'sd700, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_NONE, '0, 1'b0, 1'b0);
   endtask

   task automatic test_register_extremes();
      program_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32767, 255, 255, 1'b1);
      send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_YAW, '0, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, gopt_pkg::GYRO_MAX, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, gopt_pkg::GYRO_MIN, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, 16'sd12345, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, 16'sd100, 1'b1, 1'b1);
      // all zero: average length zero acts as one
      program_regs(24'h000000, 24'h000000, 24'h000000, 0, 0, 0, 1'b0);
      send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_PITCH, '0, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL, 16'sd1000, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH, -16'sd1000, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, 16'sd500, 1'b0, 1'b0);
      send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, -16'sd500, 1'b0, 1'b0);
   endtask

   // roll: high limit below low limit; yaw: disabled by yaw_enable; pitch tunes
   task automatic test_disabled_axes();
      program_regs(24'h000064, 24'hC8FF32, 24'h100520, 2, 0, 3, 1'b0);
      send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_ROLL, '0, 1'b0, 1'b0);
      for (int k = 0; k < 4; k++) begin
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_ROLL,
                   gopt_pkg::GYRO_W'(-5000 * (k + 1)), 1'b0, 1'b0);
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_PITCH,
                   gopt_pkg::GYRO_W'(3000 * (k + 1)), 1'b0, 1'b0);
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW,
                   gopt_pkg::GYRO_W'(-2000 * (k + 1)), 1'b0, 1'b0);
      end
   endtask

   // drive the yaw accumulator to its top, then down past its bottom
   task automatic test_accumulator_saturation();
      int err_mag;
      program_regs(24'h000000, 24'hFFFFFF, 24'h000000, 0, 1, 255, 1'b1);
      send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_YAW, '0, 1'b0, 1'b0);
      err_mag = 64;
      for (int k = 0; k < 100; k++) begin
         err_mag += 32 * $urandom_range(8, 16);
         if (err_mag > 32736) err_mag = 32736;
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, gopt_pkg::GYRO_W'(-err_mag),
                   1'b0, 1'($urandom_range(1)));
      end
      for (int k = 0; k < 220 && err_mag > 160; k++) begin
         err_mag -= 32 * $urandom_range(1, 4);
         send_item(gopt_pkg::CMD_SAMPLE, gopt_pkg::AXIS_YAW, gopt_pkg::GYRO_W'(-err_mag),
                   1'b0, 1'($urandom_range(1)));
      end
   endtask

   task automatic test_random_traffic();
      logic [gopt_pkg::LIM_W-1:0] lo, hi, init;
      int settle, avgc, phase_no;
      phase_no = 0;
      while (items_accepted < ITEM_TARGET) begin
         for (int ax = 0; ax < gopt_pkg::NUM_AXES; ax++) begin
            lo[gopt_pkg::GAIN_W*ax +: gopt_pkg::GAIN_W] =
               gopt_pkg::GAIN_W'($urandom_range(40));
            hi[gopt_pkg::GAIN_W*ax +: gopt_pkg::GAIN_W] =
               ($urandom_range(7) == 0) ? '0 : gopt_pkg::GAIN_W'($urandom_range(255));
            init[gopt_pkg::GAIN_W*ax +: gopt_pkg::GAIN_W] =
               gopt_pkg::GAIN_W'($urandom_range(255));
         end
         settle = ($urandom_range(3) == 0) ? $urandom_range(6) : 0;
         avgc = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(1, 6);
         program_regs(lo, hi, init, settle, avgc, $urandom_range(255), $urandom_range(5) != 0);
         idle_on <= (phase_no != 1);
         send_item(gopt_pkg::CMD_RESTART, gopt_pkg::AXIS_W'($urandom_range(2)), '0,
                   1'b0, 1'b0);
         if (phase_no == 3)
            hold_req <= hold_req + 1;
         repeat ($urandom_range(60, 110)) begin
            if (items_accepted < ITEM_TARGET)
               send_random_item();
         end
         phase_no++;
      end
   endtask

   // result side: random ready, long hold on request, compare each transfer
   initial begin
      gain_report_type want;
      int hold_seen, hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (gain_reports_due.size() == 0) begin
               $error("unexpected result: out_axis %0d gain %0d", rsp_chan.out_axis,
                      rsp_chan.gain);
               mismatch_count++;
            end else begin
               want = gain_reports_due.pop_front();
               if (rsp_chan.out_axis !== want.axis) begin
                  $error("out_axis: expected %0d, actual %0d", want.axis, rsp_chan.out_axis);
                  mismatch_count++;
               end
               if (rsp_chan.gain !== want.gain) begin
                  $error("gain: expected %0d, actual %0d", want.gain, rsp_chan.gain);
                  mismatch_count++;
               end
               if (rsp_chan.gain_updated !== want.updated) begin
                  $error("gain_updated: expected %0d, actual %0d", want.updated,
                         rsp_chan.gain_updated);
                  mismatch_count++;
               end
               if (rsp_chan.average_rate !== want.rate) begin
                  $error("average_rate: expected %0d, actual %0d", want.rate,
                         rsp_chan.average_rate);
                  mismatch_count++;
               end
            end
         end
         if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= gopt_pkg::CMD_SAMPLE;
      req_chan.axis         <= gopt_pkg::AXIS_ROLL;
      req_chan.gyro_sample  <= '0;
      req_chan.stick_active <= 1'b0;
      req_chan.level_mode   <= 1'b0;
      csr_we                <= 1'b0;
      csr_index             <= gopt_pkg::CSR_LOW_LIMITS;
      csr_wdata             <= '0;
      cfg_low    = '0;
      cfg_high   = '0;
      cfg_init   = '0;
      cfg_settle = 0;
      cfg_avgc   = int'(gopt_pkg::AVGC_RESET);
      cfg_boost  = 0;
      cfg_yaw_en = 1'b1;
      for (int ax = 0; ax < gopt_pkg::NUM_AXES; ax++) begin
         rate_acc[ax]  = 0;
         last_avg[ax]  = 0;
         walk_rate[ax] = 0;
      end
      restart_axes();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_register_extremes();
      test_disabled_axes();
      test_accumulator_saturation();
      test_random_traffic();

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && gain_reports_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/gopt_pkg.sv
hw/rtl/gopt_if.sv
hw/rtl/gopt_div.sv
hw/rtl/gopt_ctrl.sv
hw/rtl/gopt_dp.sv
hw/rtl/gyro_oscillation_p_gain_tuner_top.sv
hw/rtl/gopt_chk.sv
dv/tb.sv
